>>> hw/rtl/spim_pkg.sv
// ----------------------------------------------------------------------------
// spim_pkg
// Shared types, register offsets and helpers for the SPI master with FIFOs.
// ----------------------------------------------------------------------------
`default_nettype none
package spim_pkg;

  localparam int SLOT_COUNT_DEF   = 8;
  localparam int CHIP_SELECTS_DEF = 1;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [1:0] CFG_PINMUX  = 2'd0;
  localparam logic [1:0] CFG_ID      = 2'd1;
  localparam logic [1:0] CFG_VERSION = 2'd2;

  localparam logic [7:0] R_CTRL0   = 8'h00;
  localparam logic [7:0] R_CTRL1   = 8'h04;
  localparam logic [7:0] R_ENABLE  = 8'h08;
  localparam logic [7:0] R_MWCR    = 8'h0C;
  localparam logic [7:0] R_SER     = 8'h10;
  localparam logic [7:0] R_BAUD    = 8'h14;
  localparam logic [7:0] R_TXTHR   = 8'h18;
  localparam logic [7:0] R_RXTHR   = 8'h1C;
  localparam logic [7:0] R_TXLVL   = 8'h20;
  localparam logic [7:0] R_RXLVL   = 8'h24;
  localparam logic [7:0] R_STATUS  = 8'h28;
  localparam logic [7:0] R_IMASK   = 8'h2C;
  localparam logic [7:0] R_ISTAT   = 8'h30;
  localparam logic [7:0] R_RISR    = 8'h34;
  localparam logic [7:0] R_TXOICR  = 8'h38;
  localparam logic [7:0] R_RXOICR  = 8'h3C;
  localparam logic [7:0] R_RXUICR  = 8'h40;
  localparam logic [7:0] R_MSTICR  = 8'h44;
  localparam logic [7:0] R_ICR     = 8'h48;
  localparam logic [7:0] R_DMACR   = 8'h4C;
  localparam logic [7:0] R_DMATDLR = 8'h50;
  localparam logic [7:0] R_DMARDLR = 8'h54;
  localparam logic [7:0] R_IDR     = 8'h58;
  localparam logic [7:0] R_VERSION = 8'h5C;
  localparam logic [7:0] R_DATA    = 8'h60;
  localparam logic [7:0] R_SDELAY  = 8'hF0;

  localparam logic [5:0] IR_TXE = 6'h01;
  localparam logic [5:0] IR_TXO = 6'h02;
  localparam logic [5:0] IR_RXU = 6'h04;
  localparam logic [5:0] IR_RXO = 6'h08;
  localparam logic [5:0] IR_RXF = 6'h10;
  localparam logic [5:0] IR_MST = 6'h20;
  localparam logic [5:0] IR_ALL = 6'h3F;

  localparam int LOOP_BIT = 11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctl_cmd_t;

  // frame length in bits, at least four
  function automatic logic [4:0] frame_bits(input logic [15:0] c0);
    logic [4:0] b;
    b = {1'b0, c0[3:0]} + 5'd1;
    return (b < 5'd4) ? 5'd4 : b;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/spim_ram.sv
// ----------------------------------------------------------------------------
// spim_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module spim_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/spim_ctrl.sv
// ----------------------------------------------------------------------------
// spim_ctrl
// Sequencer: accept, fetch FIFO heads, execute, strobe result.
// ----------------------------------------------------------------------------
`default_nettype none
module spim_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output logic                     done,
  output spim_pkg::ctl_cmd_t       cmd
);

  spim_pkg::state_t state;
  spim_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      spim_pkg::ST_IDLE: begin
        if (start) state_next = spim_pkg::ST_FETCH;
      end
      spim_pkg::ST_FETCH: state_next = spim_pkg::ST_EXEC;
      spim_pkg::ST_EXEC:  state_next = spim_pkg::ST_IDLE;
      default:            state_next = spim_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.load = 1'b0;
    cmd.exec = 1'b0;
    busy     = 1'b1;
    case (state)
      spim_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      spim_pkg::ST_FETCH: ;
      spim_pkg::ST_EXEC:  cmd.exec = 1'b1;
      default:            busy = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spim_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spim_dp.sv
// ----------------------------------------------------------------------------
// spim_dp
// Register file, FIFO pointers, frame timer and result registers.
// ----------------------------------------------------------------------------
`default_nettype none
module spim_dp #(
  parameter int SLOT_COUNT   = spim_pkg::SLOT_COUNT_DEF,
  parameter int CHIP_SELECTS = spim_pkg::CHIP_SELECTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire spim_pkg::ctl_cmd_t cmd,
  input  wire logic [1:0]         action,
  input  wire logic [7:0]         address,
  input  wire logic [1:0]         size_code,
  input  wire logic [31:0]        write_data,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output logic      [31:0]        read_data,
  output logic                    response,
  output logic                    irq_level
);

  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  // configuration
  logic        mux_en;
  logic [31:0] id_word, version_word;

  // latched item
  logic [1:0]  in_act;
  logic [7:0]  in_addr;
  logic [1:0]  in_size;
  logic [31:0] in_wd;

  // state
  logic [15:0] ctrl0, ctrl1, baud;
  logic        enabled, fbusy;
  logic [31:0] mwcr, dtx, drx, sdel;
  logic [CHIP_SELECTS-1:0] ss;
  logic [7:0]  txthr, rxthr;
  logic [5:0]  imask, sticky;
  logic [CW-1:0] txc, rxc;
  logic [AW-1:0] txh, rxh;
  logic [19:0] ftl;

  logic [15:0] ctrl0_next, ctrl1_next, baud_next;
  logic        enabled_next, fbusy_next;
  logic [31:0] mwcr_next, dtx_next, drx_next, sdel_next;
  logic [CHIP_SELECTS-1:0] ss_next;
  logic [7:0]  txthr_next, rxthr_next;
  logic [5:0]  imask_next, sticky_next;
  logic [CW-1:0] txc_next, rxc_next;
  logic [AW-1:0] txh_next, rxh_next;
  logic [19:0] ftl_next;
  logic [31:0] rd_next;
  logic        resp_next, irq_next;

  // FIFO memories
  logic          tx_we, rx_we;
  logic [AW-1:0] tx_waddr, rx_waddr;
  logic [15:0]   tx_wdata, rx_wdata, tx_rdata, rx_rdata;
  logic [CW:0]   tx_sum, rx_sum;

  // step decode
  logic        err;
  logic [7:0]  off;
  logic [4:0]  sh;
  logic [31:0] lm, val, merged, base;
  logic [5:0]  raw;
  logic [19:0] ftl_dec;
  logic [20:0] flen;
  logic [15:0] wmask;

  spim_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(tx_wdata),
    .raddr(txh), .rdata(tx_rdata)
  );

  spim_ram #(.WIDTH(16), .DEPTH(SLOT_COUNT)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_waddr), .wdata(rx_wdata),
    .raddr(rxh), .rdata(rx_rdata)
  );

  // tail slot = (head + count) mod depth
  always_comb begin
    tx_sum   = (CW+1)'(txh) + (CW+1)'(txc);
    rx_sum   = (CW+1)'(rxh) + (CW+1)'(rxc);
    tx_waddr = AW'((tx_sum >= (CW+1)'(SLOT_COUNT)) ? tx_sum - (CW+1)'(SLOT_COUNT) : tx_sum);
    rx_waddr = AW'((rx_sum >= (CW+1)'(SLOT_COUNT)) ? rx_sum - (CW+1)'(SLOT_COUNT) : rx_sum);
  end

  always_comb begin
    ctrl0_next  = ctrl0;   ctrl1_next  = ctrl1;   baud_next   = baud;
    enabled_next = enabled; fbusy_next = fbusy;
    mwcr_next   = mwcr;    dtx_next    = dtx;     drx_next    = drx;
    sdel_next   = sdel;    ss_next     = ss;
    txthr_next  = txthr;   rxthr_next  = rxthr;
    imask_next  = imask;   sticky_next = sticky;
    txc_next    = txc;     rxc_next    = rxc;
    txh_next    = txh;     rxh_next    = rxh;
    ftl_next    = ftl;
    tx_we = 1'b0; rx_we = 1'b0;
    wmask    = 16'hFFFF >> (5'd16 - spim_pkg::frame_bits(ctrl0));
    tx_wdata = 16'h0;
    rx_wdata = tx_rdata;
    rd_next  = 32'h0;
    resp_next = 1'b0;
    val = 32'h0;
    base = 32'h0;
    merged = 32'h0;
    ftl_dec = 20'h0;

    off = {in_addr[7:2], 2'b00};
    sh  = {in_addr[1:0], 3'b000};
    case (in_size)
      spim_pkg::SIZE_BYTE: lm = 32'h0000_00FF;
      spim_pkg::SIZE_HALF: lm = 32'h0000_FFFF;
      default:             lm = 32'hFFFF_FFFF;
    endcase
    err = (in_size == 2'd3) ||
          (in_size == spim_pkg::SIZE_HALF && in_addr[0]) ||
          (in_size == spim_pkg::SIZE_WORD && in_addr[1:0] != 2'b00);

    raw = sticky;
    if (32'(txc) <= 32'(txthr)) raw = raw | spim_pkg::IR_TXE;
    if (32'(rxc) > 32'(rxthr))  raw = raw | spim_pkg::IR_RXF;

    if (in_act == spim_pkg::ACT_READ || in_act == spim_pkg::ACT_WRITE) begin
      if (err) begin
        resp_next = 1'b1;
      end else if (in_act == spim_pkg::ACT_READ) begin
        case (off)
          spim_pkg::R_CTRL0:   val = 32'(ctrl0);
          spim_pkg::R_CTRL1:   val = 32'(ctrl1);
          spim_pkg::R_ENABLE:  val = 32'(enabled);
          spim_pkg::R_MWCR:    val = mwcr;
          spim_pkg::R_SER:     val = 32'(ss);
          spim_pkg::R_BAUD:    val = 32'(baud);
          spim_pkg::R_TXTHR:   val = 32'(txthr);
          spim_pkg::R_RXTHR:   val = 32'(rxthr);
          spim_pkg::R_TXLVL:   val = 32'(txc);
          spim_pkg::R_RXLVL:   val = 32'(rxc);
          spim_pkg::R_STATUS:  val = {27'h0, rxc == CW'(SLOT_COUNT), rxc != '0,
                                      txc == '0, txc < CW'(SLOT_COUNT), fbusy};
          spim_pkg::R_IMASK:   val = 32'(imask);
          spim_pkg::R_ISTAT:   val = 32'(raw & imask);
          spim_pkg::R_RISR:    val = 32'(raw);
          spim_pkg::R_TXOICR: begin
            val = 32'(sticky & spim_pkg::IR_TXO);
            sticky_next = sticky & ~spim_pkg::IR_TXO;
          end
          spim_pkg::R_RXOICR: begin
            val = 32'(sticky & spim_pkg::IR_RXO);
            sticky_next = sticky & ~spim_pkg::IR_RXO;
          end
          spim_pkg::R_RXUICR: begin
            val = 32'(sticky & spim_pkg::IR_RXU);
            sticky_next = sticky & ~spim_pkg::IR_RXU;
          end
          spim_pkg::R_MSTICR: begin
            val = 32'(sticky & spim_pkg::IR_MST);
            sticky_next = sticky & ~spim_pkg::IR_MST;
          end
          spim_pkg::R_ICR: begin
            val = 32'(sticky);
            sticky_next = 6'h0;
          end
          spim_pkg::R_DMATDLR: val = dtx;
          spim_pkg::R_DMARDLR: val = drx;
          spim_pkg::R_IDR:     val = id_word;
          spim_pkg::R_VERSION: val = version_word;
          spim_pkg::R_DATA: begin
            if (rxc == '0) begin
              sticky_next = sticky | spim_pkg::IR_RXU;
            end else begin
              val = 32'(rx_rdata);
              rxh_next = (rxh == AW'(SLOT_COUNT - 1)) ? '0 : rxh + AW'(1);
              rxc_next = rxc - CW'(1);
            end
          end
          spim_pkg::R_SDELAY:  val = sdel;
          default:             val = 32'h0;
        endcase
        rd_next = (val >> sh) & lm;
      end else begin
        case (off)
          spim_pkg::R_CTRL0:   base = 32'(ctrl0);
          spim_pkg::R_CTRL1:   base = 32'(ctrl1);
          spim_pkg::R_ENABLE:  base = 32'(enabled);
          spim_pkg::R_MWCR:    base = mwcr;
          spim_pkg::R_SER:     base = 32'(ss);
          spim_pkg::R_BAUD:    base = 32'(baud);
          spim_pkg::R_TXTHR:   base = 32'(txthr);
          spim_pkg::R_RXTHR:   base = 32'(rxthr);
          spim_pkg::R_IMASK:   base = 32'(imask);
          spim_pkg::R_DMATDLR: base = dtx;
          spim_pkg::R_DMARDLR: base = drx;
          spim_pkg::R_SDELAY:  base = sdel;
          default:             base = 32'h0;
        endcase
        merged = (base & ~(lm << sh)) | ((in_wd & lm) << sh);
        case (off)
          spim_pkg::R_CTRL0: if (!enabled) ctrl0_next = merged[15:0];
          spim_pkg::R_CTRL1: if (!enabled) ctrl1_next = merged[15:0];
          spim_pkg::R_ENABLE: begin
            enabled_next = merged[0];
            if (!merged[0]) begin
              fbusy_next = 1'b0;
              ftl_next   = 20'h0;
              txc_next = '0; txh_next = '0; rxc_next = '0; rxh_next = '0;
            end
          end
          spim_pkg::R_MWCR: if (!enabled) mwcr_next = merged;
          spim_pkg::R_SER:  ss_next = merged[CHIP_SELECTS-1:0];
          spim_pkg::R_BAUD: begin
            if (!enabled) begin
              baud_next = (merged[15:1] == 15'h0) ? 16'd2 : {merged[15:1], 1'b0};
            end
          end
          spim_pkg::R_TXTHR: txthr_next = (merged > 32'(SLOT_COUNT - 1)) ?
                                          8'(SLOT_COUNT - 1) : merged[7:0];
          spim_pkg::R_RXTHR: rxthr_next = (merged > 32'(SLOT_COUNT - 1)) ?
                                          8'(SLOT_COUNT - 1) : merged[7:0];
          spim_pkg::R_IMASK:   imask_next = merged[5:0];
          spim_pkg::R_DMATDLR: dtx_next = merged;
          spim_pkg::R_DMARDLR: drx_next = merged;
          spim_pkg::R_DATA: begin
            if (txc >= CW'(SLOT_COUNT)) begin
              sticky_next = sticky | spim_pkg::IR_TXO;
            end else begin
              tx_we    = 1'b1;
              tx_wdata = merged[15:0] & wmask;
              txc_next = txc + CW'(1);
            end
          end
          spim_pkg::R_SDELAY: sdel_next = merged;
          default: ;
        endcase
      end
    end else if (in_act == spim_pkg::ACT_TICK) begin
      if (fbusy) begin
        ftl_dec  = (ftl != 20'h0) ? ftl - 20'd1 : 20'h0;
        ftl_next = ftl_dec;
        if (ftl_dec == 20'h0) begin
          fbusy_next = 1'b0;
          if (txc != '0) begin
            txh_next = (txh == AW'(SLOT_COUNT - 1)) ? '0 : txh + AW'(1);
            txc_next = txc - CW'(1);
            if (mux_en && ctrl0[spim_pkg::LOOP_BIT]) begin
              if (rxc >= CW'(SLOT_COUNT)) begin
                sticky_next = sticky | spim_pkg::IR_RXO;
              end else begin
                rx_we    = 1'b1;
                rxc_next = rxc + CW'(1);
              end
            end
          end
        end
      end
    end

    // start the next frame once enabled and idle with data queued
    flen = 21'(spim_pkg::frame_bits(ctrl0_next)) * 21'(baud_next);
    if (enabled_next && !fbusy_next && txc_next != '0) begin
      fbusy_next = 1'b1;
      ftl_next   = flen[19:0];
    end

    irq_next = 1'b0;
    if (32'(txc_next) <= 32'(txthr_next) && imask_next[0]) irq_next = 1'b1;
    if (32'(rxc_next) > 32'(rxthr_next) && imask_next[4]) irq_next = 1'b1;
    if ((sticky_next & imask_next) != 6'h0) irq_next = 1'b1;

    tx_we = tx_we & cmd.exec;
    rx_we = rx_we & cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mux_en        <= 1'b0;
      id_word       <= 32'h0;
      version_word  <= 32'h0;
    end else if (cfg_we) begin
      case (cfg_index)
        spim_pkg::CFG_PINMUX:  mux_en        <= cfg_data[0];
        spim_pkg::CFG_ID:      id_word       <= cfg_data;
        spim_pkg::CFG_VERSION: version_word  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_act  <= action;
      in_addr <= address;
      in_size <= size_code;
      in_wd   <= write_data;
    end
    if (cmd.exec) begin
      read_data <= rd_next;
      response  <= resp_next;
      irq_level <= irq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl0 <= 16'd7;  ctrl1 <= 16'h0;  baud <= 16'd2;
      enabled <= 1'b0; fbusy <= 1'b0;
      mwcr <= 32'h0;   dtx <= 32'h0;    drx <= 32'h0;   sdel <= 32'h0;
      ss <= '0;        txthr <= 8'h0;   rxthr <= 8'h0;
      imask <= 6'h0;   sticky <= 6'h0;
      txc <= '0;       rxc <= '0;       txh <= '0;      rxh <= '0;
      ftl <= 20'h0;
    end else if (cmd.exec) begin
      ctrl0 <= ctrl0_next;  ctrl1 <= ctrl1_next;  baud <= baud_next;
      enabled <= enabled_next; fbusy <= fbusy_next;
      mwcr <= mwcr_next;    dtx <= dtx_next;      drx <= drx_next;
      sdel <= sdel_next;    ss <= ss_next;
      txthr <= txthr_next;  rxthr <= rxthr_next;
      imask <= imask_next;  sticky <= sticky_next;
      txc <= txc_next;      rxc <= rxc_next;
      txh <= txh_next;      rxh <= rxh_next;
      ftl <= ftl_next;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/spi_master_controller_fifo.sv
// ----------------------------------------------------------------------------
// spi_master_controller_fifo
// Register-mapped SPI master with TX/RX FIFOs and frame timer.
// ----------------------------------------------------------------------------
// channel  | handshake        | payload
// item in  | start & !busy    | action, address, size_code, write_data
// result   | done (1 cycle)   | read_data, response, irq_level
// config   | cfg_we           | cfg_index, cfg_data
//
// Each beat passes through accept, FIFO head fetch (registered RAM read),
// execute. done pulses in the cycle after execute, when busy is already low.
// Synchronous active-high reset; FIFO contents are not cleared.
// The receiver cannot stall; a result shows for exactly one cycle.
`default_nettype none
module spi_master_controller_fifo #(
  parameter int SLOT_COUNT   = spim_pkg::SLOT_COUNT_DEF,
  parameter int CHIP_SELECTS = spim_pkg::CHIP_SELECTS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  action,
  input  wire logic [7:0]  address,
  input  wire logic [1:0]  size_code,
  input  wire logic [31:0] write_data,
  output logic             done,
  output logic      [31:0] read_data,
  output logic             response,
  output logic             irq_level,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  spim_pkg::ctl_cmd_t cmd;

  spim_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .cmd(cmd)
  );

  spim_dp #(.SLOT_COUNT(SLOT_COUNT), .CHIP_SELECTS(CHIP_SELECTS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd),
    .action(action), .address(address), .size_code(size_code),
    .write_data(write_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .read_data(read_data), .response(response), .irq_level(irq_level)
  );

endmodule
`default_nettype wire

>>> hw/rtl/spim_checker.sv
// ----------------------------------------------------------------------------
// spim_checker
// Port-level timing checks for the SPI master, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module spim_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] read_data,
  input wire logic        response
);

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result not delivered three cycles after accept");

  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("done while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response) |-> (read_data == 32'h0))
    else $error("error response with nonzero data");

  a_reset: assert property (@(posedge clk)
    rst |=> (!busy && !done))
    else $error("not idle after reset");

endmodule

bind spi_master_controller_fifo spim_checker u_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .read_data(read_data), .response(response)
);
`default_nettype wire

>>> sim/tb_spi_master_controller_fifo.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_spi_master_controller_fifo
// Drives bus reads, writes and clock ticks into the SPI master, models the
// register file, both FIFOs and the frame timer, and checks every result.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_spi_master_controller_fifo;

  localparam int DEPTH = spim_pkg::SLOT_COUNT_DEF;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [31:0] rdata;
    logic        resp;
    logic        irq;
  } outcome_t;

  // predictor of the controller
  class spim_scoreboard;
    bit [31:0] pinmux, id_w, ver_w;
    bit [15:0] c0, c1, ser, baud;
    bit        en, busy_f;
    bit [31:0] mwcr, dtl, drl, sdly;
    bit [7:0]  txthr, rxthr;
    bit [5:0]  imask, sticky;
    bit [15:0] txq[DEPTH], rxq[DEPTH];
    int        txc, txh, rxc, rxh;
    bit [19:0] ticks_left;
    outcome_t  pending[$];
    int        errors, beats, loops;

    function void clear();
      c0 = 16'd7; c1 = 0; en = 0; mwcr = 0; ser = 0; baud = 16'd2;
      txthr = 0; rxthr = 0; imask = 0; sticky = 0; dtl = 0; drl = 0; sdly = 0;
      txc = 0; txh = 0; rxc = 0; rxh = 0; busy_f = 0; ticks_left = 0;
      pinmux = 0; id_w = 0; ver_w = 0;
    endfunction

    function int fbits();
      int b;
      b = c0[3:0] + 1;
      return b < 4 ? 4 : b;
    endfunction

    function bit [5:0] raw();
      bit [5:0] v;
      v = sticky;
      if (txc <= txthr) v |= spim_pkg::IR_TXE;
      if (rxc > rxthr) v |= spim_pkg::IR_RXF;
      return v;
    endfunction

    function bit [31:0] take(bit [5:0] bits);
      bit [31:0] v;
      v = sticky & bits;
      sticky &= ~bits;
      return v;
    endfunction

    function bit [31:0] fetch(bit [7:0] off);
      bit [31:0] v;
      v = 0;
      case (off)
        spim_pkg::R_CTRL0:   v = c0;
        spim_pkg::R_CTRL1:   v = c1;
        spim_pkg::R_ENABLE:  v = en;
        spim_pkg::R_MWCR:    v = mwcr;
        spim_pkg::R_SER:     v = ser;
        spim_pkg::R_BAUD:    v = baud;
        spim_pkg::R_TXTHR:   v = txthr;
        spim_pkg::R_RXTHR:   v = rxthr;
        spim_pkg::R_TXLVL:   v = txc;
        spim_pkg::R_RXLVL:   v = rxc;
        spim_pkg::R_STATUS:
          v = {27'd0, rxc == DEPTH, rxc != 0, txc == 0, txc < DEPTH, busy_f};
        spim_pkg::R_IMASK:   v = imask;
        spim_pkg::R_ISTAT:   v = raw() & imask;
        spim_pkg::R_RISR:    v = raw();
        spim_pkg::R_TXOICR:  v = take(spim_pkg::IR_TXO);
        spim_pkg::R_RXOICR:  v = take(spim_pkg::IR_RXO);
        spim_pkg::R_RXUICR:  v = take(spim_pkg::IR_RXU);
        spim_pkg::R_MSTICR:  v = take(spim_pkg::IR_MST);
        spim_pkg::R_ICR:     v = take(spim_pkg::IR_ALL);
        spim_pkg::R_DMATDLR: v = dtl;
        spim_pkg::R_DMARDLR: v = drl;
        spim_pkg::R_IDR:     v = id_w;
        spim_pkg::R_VERSION: v = ver_w;
        spim_pkg::R_DATA: begin
          if (rxc == 0) sticky |= spim_pkg::IR_RXU;
          else begin
            v = rxq[rxh];
            rxh = (rxh + 1) % DEPTH;
            rxc--;
          end
        end
        spim_pkg::R_SDELAY:  v = sdly;
        default:             v = 0;
      endcase
      return v;
    endfunction

    function bit [31:0] base(bit [7:0] off);
      case (off)
        spim_pkg::R_CTRL0:   return c0;
        spim_pkg::R_CTRL1:   return c1;
        spim_pkg::R_ENABLE:  return en;
        spim_pkg::R_MWCR:    return mwcr;
        spim_pkg::R_SER:     return ser;
        spim_pkg::R_BAUD:    return baud;
        spim_pkg::R_TXTHR:   return txthr;
        spim_pkg::R_RXTHR:   return rxthr;
        spim_pkg::R_IMASK:   return imask;
        spim_pkg::R_DMATDLR: return dtl;
        spim_pkg::R_DMARDLR: return drl;
        spim_pkg::R_SDELAY:  return sdly;
        default:             return 0;
      endcase
    endfunction

    function bit [7:0] sat(bit [31:0] v);
      return v > DEPTH - 1 ? DEPTH - 1 : v[7:0];
    endfunction

    function void store(bit [7:0] off, bit [31:0] v);
      bit [31:0] b;
      case (off)
        spim_pkg::R_CTRL0:   if (!en) c0 = v[15:0];
        spim_pkg::R_CTRL1:   if (!en) c1 = v[15:0];
        spim_pkg::R_ENABLE: begin
          en = v[0];
          if (!en) begin
            busy_f = 0; ticks_left = 0; txc = 0; txh = 0; rxc = 0; rxh = 0;
          end
        end
        spim_pkg::R_MWCR:    if (!en) mwcr = v;
        spim_pkg::R_SER:     ser = v & ((1 << spim_pkg::CHIP_SELECTS_DEF) - 1);
        spim_pkg::R_BAUD: begin
          if (!en) begin
            b = v & 32'hFFFE;
            baud = b < 2 ? 16'd2 : b[15:0];
          end
        end
        spim_pkg::R_TXTHR:   txthr = sat(v);
        spim_pkg::R_RXTHR:   rxthr = sat(v);
        spim_pkg::R_IMASK:   imask = v[5:0];
        spim_pkg::R_DMATDLR: dtl = v;
        spim_pkg::R_DMARDLR: drl = v;
        spim_pkg::R_DATA: begin
          if (txc >= DEPTH) sticky |= spim_pkg::IR_TXO;
          else begin
            txq[(txh + txc) % DEPTH] = v & ((32'd1 << fbits()) - 1);
            txc++;
          end
        end
        spim_pkg::R_SDELAY:  sdly = v;
        default: ;
      endcase
    endfunction

    function void tick();
      bit [15:0] w;
      if (!busy_f) return;
      if (ticks_left > 0) ticks_left--;
      if (ticks_left == 0) begin
        if (txc > 0) begin
          w = txq[txh];
          txh = (txh + 1) % DEPTH;
          txc--;
          busy_f = 0;
          if (pinmux[0] && c0[spim_pkg::LOOP_BIT]) begin
            if (rxc >= DEPTH) sticky |= spim_pkg::IR_RXO;
            else begin
              rxq[(rxh + rxc) % DEPTH] = w;
              rxc++;
              loops++;
            end
          end
        end else busy_f = 0;
      end
    endfunction

    // note an accepted input beat
    function void note(bit [1:0] act, bit [7:0] addr, bit [1:0] sz, bit [31:0] wd);
      outcome_t o;
      int len, sh;
      bit [31:0] lm, v;
      o = '0;
      beats++;
      if (act == spim_pkg::ACT_READ || act == spim_pkg::ACT_WRITE) begin
        len = sz == spim_pkg::SIZE_BYTE ? 1 : (sz == spim_pkg::SIZE_HALF ? 2 : 4);
        if (sz == 2'd3 || (addr % len) != 0 || (addr & 3) + len > 4) o.resp = 1;
        else begin
          sh = 8 * (addr & 3);
          lm = len == 4 ? 32'hFFFF_FFFF : ((32'd1 << (8 * len)) - 1);
          if (act == spim_pkg::ACT_READ) o.rdata = (fetch(addr & 8'hFC) >> sh) & lm;
          else begin
            v = base(addr & 8'hFC);
            v = (v & ~(lm << sh)) | ((wd & lm) << sh);
            store(addr & 8'hFC, v);
          end
        end
      end else if (act == spim_pkg::ACT_TICK) tick();
      if (en && !busy_f && txc > 0) begin
        busy_f = 1;
        ticks_left = fbits() * baud;
      end
      o.irq = (raw() & imask) != 0;
      pending.insert(pending.size(), o);
    endfunction

    function void check(bit [31:0] rd, bit rs, bit iq);
      outcome_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: rd=%h resp=%0d irq=%0d",
                 $time, rd, rs, iq);
        errors++;
        return;
      end
      e = pending[0];
      pending.delete(0);
      if (e.rdata !== rd) begin
        $display("%0t: read_data exp %h got %h", $time, e.rdata, rd); errors++;
      end
      if (e.resp !== rs) begin
        $display("%0t: response exp %0d got %0d", $time, e.resp, rs); errors++;
      end
      if (e.irq !== iq) begin
        $display("%0t: irq_level exp %0d got %0d", $time, e.irq, iq); errors++;
      end
    endfunction
  endclass

  logic        clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic [1:0]  action = 0, size_code = 0, cfg_index = 0;
  logic [7:0]  address = 0;
  logic [31:0] write_data = 0, cfg_data = 0;
  logic        busy, done, response, irq_level;
  logic [31:0] read_data;
  int          cycles = 0;
  spim_scoreboard sb;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  spi_master_controller_fifo i_dut (
    .clk, .rst, .start, .busy, .action, .address, .size_code, .write_data,
    .done, .read_data, .response, .irq_level, .cfg_we, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (done && !rst) sb.check(read_data, response, irq_level);
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_spi_master_controller_fifo: errors");
      $finish;
    end
  end

  // start stays high into the next beat when no idle cycles are drawn
  task automatic issue(bit [1:0] act, bit [7:0] addr, bit [1:0] sz, bit [31:0] wd,
                       bit gaps = 1);
    int g;
    g = gaps && ($urandom_range(0, 3) != 0) ? $urandom_range(0, 6) : 0;
    if (g > 0) begin
      start <= 0;
      repeat (g) @(posedge clk);
    end
    start <= 1; action <= act; address <= addr; size_code <= sz; write_data <= wd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(act, addr, sz, wd);
  endtask

  task automatic set_cfg(bit [1:0] idx, bit [31:0] val);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == spim_pkg::CFG_PINMUX) sb.pinmux = val & 1;
    else if (idx == spim_pkg::CFG_ID) sb.id_w = val;
    else sb.ver_w = val;
  endtask

  task automatic wr(bit [7:0] addr, bit [31:0] wd);
    issue(spim_pkg::ACT_WRITE, addr, spim_pkg::SIZE_WORD, wd);
  endtask

  task automatic rd(bit [7:0] addr);
    issue(spim_pkg::ACT_READ, addr, spim_pkg::SIZE_WORD, 0);
  endtask

  // clock ticks and mostly legal accesses to mapped registers, biased toward the data port
  task automatic random_beat();
    bit [7:0]  a;
    bit [1:0]  sz, act;
    bit [31:0] wd;
    int        r;
    r = $urandom_range(0, 99);
    act = r < 35 ? spim_pkg::ACT_TICK :
          (r < 65 ? spim_pkg::ACT_WRITE : (r < 98 ? spim_pkg::ACT_READ : 2'd3));
    sz = $urandom_range(0, 9) == 0 ? $urandom_range(0, 3) : spim_pkg::SIZE_WORD;
    wd = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2:  a = spim_pkg::R_DATA;
      3:        a = $urandom_range(0, 255);
      4:        a = spim_pkg::R_ENABLE;
      default:  a = 4 * $urandom_range(0, 24);
    endcase
    if (sz != spim_pkg::SIZE_WORD && $urandom_range(0, 1)) a = a | $urandom_range(0, 3);
    if (a == spim_pkg::R_ENABLE && act == spim_pkg::ACT_WRITE && $urandom_range(0, 3) != 0)
      wd[0] = 1;
    if (a == spim_pkg::R_CTRL0 && act == spim_pkg::ACT_WRITE) begin
      wd[3:0] = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4);
      wd[spim_pkg::LOOP_BIT] = $urandom_range(0, 3) != 0;
    end
    if (a == spim_pkg::R_BAUD && act == spim_pkg::ACT_WRITE && $urandom_range(0, 3) != 0)
      wd = $urandom_range(0, 5);
    issue(act, a, sz, wd);
  endtask

  initial begin
    bit [31:0] ids[3];
    sb = new();
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    ids = '{32'hFFFF_FFFF, 32'h0, 32'hA5C3_0F96};
    set_cfg(spim_pkg::CFG_PINMUX, 1);
    set_cfg(spim_pkg::CFG_ID, ids[0]);
    set_cfg(spim_pkg::CFG_VERSION, 32'h0);

    // directed: id/version, sizes and bad alignment, loopback, flags
    rd(spim_pkg::R_IDR); rd(spim_pkg::R_VERSION);
    issue(spim_pkg::ACT_READ, spim_pkg::R_IDR + 1, spim_pkg::SIZE_BYTE, 0);
    issue(spim_pkg::ACT_READ, spim_pkg::R_IDR + 2, spim_pkg::SIZE_HALF, 0);
    issue(spim_pkg::ACT_READ, spim_pkg::R_IDR + 1, spim_pkg::SIZE_HALF, 0);
    issue(spim_pkg::ACT_READ, spim_pkg::R_IDR + 2, spim_pkg::SIZE_WORD, 0);
    issue(spim_pkg::ACT_WRITE, spim_pkg::R_SDELAY, 2'd3, 32'hFFFF_FFFF);
    issue(spim_pkg::ACT_TICK, 8'hFF, 2'd3, 32'hFFFF_FFFF);
    rd(spim_pkg::R_DATA);
    wr(spim_pkg::R_IMASK, 32'hFFFF_FFFF);
    wr(spim_pkg::R_CTRL0, 32'h0000_0800);
    wr(spim_pkg::R_BAUD, 32'h0000_0001);
    wr(spim_pkg::R_RXTHR, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++) wr(spim_pkg::R_DATA, 32'hFFFF_FFFF);
    wr(spim_pkg::R_ENABLE, 1);
    wr(spim_pkg::R_CTRL0, 32'h0);
    for (int i = 0; i < 50; i++) issue(spim_pkg::ACT_TICK, 0, 0, 0, 0);
    rd(spim_pkg::R_STATUS); rd(spim_pkg::R_DATA); rd(spim_pkg::R_ICR);
    wr(spim_pkg::R_ENABLE, 0);

    for (int ph = 0; ph < 4; ph++) begin
      set_cfg(spim_pkg::CFG_PINMUX, ph != 2);
      set_cfg(spim_pkg::CFG_ID, ph < 3 ? ids[ph] : $urandom);
      set_cfg(spim_pkg::CFG_VERSION, ph == 0 ? 32'hFFFF_FFFF : $urandom);
      for (int i = 0; i < 118; i++) begin
        // idle-free stretches now and then
        if (i % 40 < 8) issue(spim_pkg::ACT_TICK, 0, 0, $urandom, 0);
        else random_beat();
      end
    end

    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("covered %0d beats over 4 pinmux/id settings, %0d frames looped back",
             sb.beats, sb.loops);
    if (sb.errors == 0) $display("tb_spi_master_controller_fifo: clean");
    else $display("tb_spi_master_controller_fifo: errors");
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
hw/rtl/spim_pkg.sv
hw/rtl/spim_ram.sv
hw/rtl/spim_ctrl.sv
hw/rtl/spim_dp.sv
hw/rtl/spi_master_controller_fifo.sv
hw/rtl/spim_checker.sv
sim/tb_spi_master_controller_fifo.sv
